@@ hw/rtl/utf8_to_code_point_decoder_assert.svh @@
// Assertion macros for the UTF-8 decoder RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef UTF8_TO_CODE_POINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODE_POINT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define U2C_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define U2C_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/u2c_pkg.sv @@
// Shared types and constants for the UTF-8 to code point decoder.
// No dependencies; used by every module of the block.
package u2c_pkg;

  localparam int BYTE_W    = 8;
  localparam int CP_W      = 21;
  localparam int CNT_W     = 2;
  localparam int M_TDATA_W = ((CP_W + 7) / 8) * 8;

  // Continuation bytes still expected after a lead byte
  localparam logic [CNT_W-1:0] LEFT_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] LEFT_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] LEFT_TWO   = 2'd2;
  localparam logic [CNT_W-1:0] LEFT_THREE = 2'd3;

  // One byte held in the input register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_item_t;

  // Decode result handed to the output register
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    logic            string_end;
  } result_t;

endpackage

@@ hw/rtl/u2c_in_reg.sv @@
// Input register stage of the UTF-8 decoder: holds one byte from the slave side.
// Depends on u2c_pkg.
module u2c_in_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [u2c_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] byte_in
  input  logic                         advance,   // downstream can take the held byte
  output u2c_pkg::byte_item_t          item
);

  logic                       held_valid;
  logic [u2c_pkg::BYTE_W-1:0] held_data;

  // Free slot, or the held byte leaves this cycle
  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held_data <= s_tdata;
    end
  end

  assign item.valid = held_valid;
  assign item.data  = held_data;

endmodule

@@ hw/rtl/u2c_decode.sv @@
// Decode core: sequence state and per-byte decode logic of the UTF-8 decoder.
// Depends on u2c_pkg and utf8_to_code_point_decoder_assert.svh.
`include "utf8_to_code_point_decoder_assert.svh"

module u2c_decode (
  input  logic                clk,
  input  logic                rst,
  input  u2c_pkg::byte_item_t item,
  input  logic                advance,   // output stage can take a result
  output logic                take,      // held byte consumed this cycle
  output u2c_pkg::result_t    res
);

  localparam int CpW = u2c_pkg::CP_W;

  logic [u2c_pkg::CNT_W-1:0] bytes_left, bytes_left_next;
  logic [CpW-1:0]            partial_value, partial_value_next;
  logic [CpW-1:0]            shifted;
  logic [u2c_pkg::BYTE_W-1:0] b;

  assign take    = item.valid && advance;
  assign b       = item.data;
  assign shifted = {partial_value[CpW-7:0], b[5:0]};

  // Next state and result for the held byte
  always_comb begin
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;
    res.valid          = 1'b0;
    res.code_point     = '0;
    res.string_end     = 1'b0;
    if (bytes_left != u2c_pkg::LEFT_NONE) begin
      // continuation: low six bits, no validation
      bytes_left_next = bytes_left - u2c_pkg::LEFT_ONE;
      if (bytes_left == u2c_pkg::LEFT_ONE) begin
        res.valid          = 1'b1;
        res.code_point     = shifted;
        partial_value_next = '0;
      end else begin
        partial_value_next = shifted;
      end
    end else if (b == '0) begin
      // end of string
      res.valid      = 1'b1;
      res.string_end = 1'b1;
    end else if (!b[7]) begin
      res.valid      = 1'b1;
      res.code_point = CpW'(b);
    end else if (!b[5]) begin
      partial_value_next = CpW'(b[4:0]);
      bytes_left_next    = u2c_pkg::LEFT_ONE;
    end else if (!b[4]) begin
      partial_value_next = CpW'(b[3:0]);
      bytes_left_next    = u2c_pkg::LEFT_TWO;
    end else if (!b[3]) begin
      partial_value_next = CpW'(b[2:0]);
      bytes_left_next    = u2c_pkg::LEFT_THREE;
    end else begin
      // bad lead byte: code point 0 at once
      res.valid          = 1'b1;
      partial_value_next = '0;
    end
    res.valid = res.valid && item.valid;
  end

  // Sequence state advances only when a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= u2c_pkg::LEFT_NONE;
      partial_value <= '0;
    end else if (take) begin
      bytes_left    <= bytes_left_next;
      partial_value <= partial_value_next;
    end
  end

  `U2C_ASSERT_NOW(a_idle_partial_clear, clk, rst,
    bytes_left == u2c_pkg::LEFT_NONE, partial_value == '0,
    "partial value not cleared between sequences")
  `U2C_ASSERT_NOW(a_end_is_zero, clk, rst,
    res.valid && res.string_end,
    res.code_point == '0 && bytes_left == u2c_pkg::LEFT_NONE,
    "end-of-string result malformed")
  `U2C_ASSERT_NOW(a_last_cont_emits, clk, rst,
    item.valid && bytes_left == u2c_pkg::LEFT_ONE, res.valid,
    "final continuation gave no result")
  `U2C_ASSERT_NEXT(a_state_holds, clk, rst,
    !take, $stable(bytes_left) && $stable(partial_value),
    "sequence state moved without a consumed byte")

endmodule

@@ hw/rtl/u2c_out_reg.sv @@
// Output register stage of the UTF-8 decoder: drives the master-side stream.
// Depends on u2c_pkg.
module u2c_out_reg (
  input  logic                              clk,
  input  logic                              rst,
  input  u2c_pkg::result_t                  res,
  input  logic                              take,     // decode core consumed a byte
  output logic                              advance,  // register free for a new result
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [u2c_pkg::M_TDATA_W-1:0]     m_tdata,  // [20:0] code_point, [23:21] zero
  output logic                              m_tlast   // string_end
);

  logic [u2c_pkg::CP_W-1:0] code_point;
  logic                     string_end;

  assign advance = !m_tvalid || m_tready;

  // Valid flag: load on a new result, clear when the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= take && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take && res.valid) begin
      code_point <= res.code_point;
      string_end <= res.string_end;
    end
  end

  assign m_tdata = u2c_pkg::M_TDATA_W'(code_point);
  assign m_tlast = string_end;

endmodule

@@ hw/rtl/utf8_to_code_point_decoder.sv @@
// UTF-8 to code point decoder, top level.
// Slave stream (s_tvalid/s_tready/s_tdata) carries one byte per transfer.
// Master stream (m_tvalid/m_tready/m_tdata/m_tlast) carries one code point per
// transfer; m_tlast marks the result of a zero byte at a lead position.
// A lead byte that opens a sequence, and every continuation but the last,
// produce no master transfer; the final byte of a sequence produces one.
// A result passes from the input register through the combinational decode into the
// output register, which presents it on the master stream.
// Throughput: one byte per cycle while the output register can advance; the decode
// between the input and output registers is combinational, and the sequence state
// updates in the same cycle as the output register loads.
// When the receiver stalls, the output register holds its result and the
// input register holds one more byte; s_tready drops only when both are full.
// Reset (rst, synchronous, active high) empties both registers and returns
// the decoder to expecting a lead byte.
// Depends on u2c_pkg, u2c_in_reg, u2c_decode and u2c_out_reg.
module utf8_to_code_point_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [u2c_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] byte_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [u2c_pkg::M_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic                          m_tlast    // string_end
);

  u2c_pkg::byte_item_t item;
  u2c_pkg::result_t    res;
  logic                advance;
  logic                take;

  u2c_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .item     (item)
  );

  u2c_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .take    (take),
    .res     (res)
  );

  u2c_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .take     (take),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_code_point_decoder: random and directed byte streams,
// a per-byte decode predictor, and an in-order check of every code point transfer.
// Depends on u2c_pkg and the decoder RTL only.
module tb;

  localparam int ByteW = u2c_pkg::BYTE_W;
  localparam int CpW   = u2c_pkg::CP_W;

  // What the sender queue holds: a byte, or a pacing marker
  typedef enum logic [1:0] {STIM_BYTE, STIM_DRAIN, STIM_HOLD} stim_kind_t;

  typedef struct {
    stim_kind_t       kind;
    logic [ByteW-1:0] data;
  } stim_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           string_end;
  } cp_result_t;

  localparam int N_BYTES   = 1950;
  localparam int HOLD_CYC  = 80;
  localparam int DRAIN_CYC = 6;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [ByteW-1:0]               s_tdata  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [u2c_pkg::M_TDATA_W-1:0]  m_tdata;
  logic                           m_tlast;

  stim_t      stim_q[$];
  cp_result_t cp_q[$];

  // Predictor state
  logic [u2c_pkg::CNT_W-1:0] seq_left  = u2c_pkg::LEFT_NONE;
  logic [CpW-1:0]            seq_value = '0;

  int   n_bytes    = 0;
  int   errors     = 0;
  bit   byte_taken = 1'b0;
  int   gap_left   = 0;
  bit   draining   = 1'b0;
  int   tx_burst   = 0;
  int   rx_burst   = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  int   hold_seq   = 0;
  int   hold_seen  = 0;
  stim_t      item;
  cp_result_t got;
  cp_result_t want;

  utf8_to_code_point_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length: mostly none or short, a few long, with occasional idle-free bursts
  function automatic int pick_gap(inout int burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (r < 3) begin
      burst = $urandom_range(50, 200);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Decode one accepted byte; queue the code point it completes, if any
  task automatic decode_byte(input logic [ByteW-1:0] b);
    if (seq_left != u2c_pkg::LEFT_NONE) begin
      seq_value = {seq_value[CpW-7:0], b[5:0]};
      seq_left  = seq_left - 1'b1;
      if (seq_left == u2c_pkg::LEFT_NONE) begin
        cp_q.push_back('{code_point: seq_value, string_end: 1'b0});
        seq_value = '0;
      end
    end else if (b == '0) begin
      cp_q.push_back('{code_point: '0, string_end: 1'b1});
    end else if (!b[7]) begin
      cp_q.push_back('{code_point: CpW'(b), string_end: 1'b0});
    end else if (!b[5]) begin
      seq_value = CpW'(b[4:0]);
      seq_left  = u2c_pkg::LEFT_ONE;
    end else if (!b[4]) begin
      seq_value = CpW'(b[3:0]);
      seq_left  = u2c_pkg::LEFT_TWO;
    end else if (!b[3]) begin
      seq_value = CpW'(b[2:0]);
      seq_left  = u2c_pkg::LEFT_THREE;
    end else begin
      // bad lead: answered at once with code point zero
      seq_value = '0;
      cp_q.push_back('{code_point: '0, string_end: 1'b0});
    end
  endtask

  task automatic log_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    stim_q.push_back('{kind: STIM_BYTE, data: b});
    n_bytes++;
  endtask

  task automatic push_marker(input stim_kind_t k);
    stim_q.push_back('{kind: k, data: '0});
  endtask

  // Well-formed sequence of 1 to 4 bytes with random payload
  task automatic push_sequence(input int len);
    case (len)
      1: push_byte(ByteW'($urandom_range(1, 127)));
      2: push_byte(8'hC0 | ByteW'($urandom_range(0, 31)));
      3: push_byte(8'hE0 | ByteW'($urandom_range(0, 15)));
      default: push_byte(8'hF0 | ByteW'($urandom_range(0, 7)));
    endcase
    for (int i = 1; i < len; i++)
      push_byte(8'h80 | ByteW'($urandom_range(0, 63)));
  endtask

  // Monitor: check output transfers, predict from input transfers
  always @(posedge clk) begin
    byte_taken = !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{code_point: m_tdata[CpW-1:0], string_end: m_tlast};
        if (cp_q.size() == 0) begin
          log_failure($sformatf("unexpected transfer: cp=%06h end=%b",
                                got.code_point, got.string_end));
        end else begin
          want = cp_q.pop_front();
          if (got.code_point !== want.code_point || got.string_end !== want.string_end)
            log_failure($sformatf("mismatch: expected cp=%06h end=%b, got cp=%06h end=%b",
                                  want.code_point, want.string_end,
                                  got.code_point, got.string_end));
        end
      end
      if (byte_taken) decode_byte(s_tdata);
    end
  end

  // Sender: one byte per transfer, random gaps, drain and hold markers
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || byte_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (draining) begin
        s_tvalid <= 1'b0;
        if (cp_q.size() == 0) begin
          draining <= 1'b0;
          gap_left <= DRAIN_CYC;
        end
      end else if (stim_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        item = stim_q.pop_front();
        case (item.kind)
          STIM_BYTE: begin
            s_tvalid <= 1'b1;
            s_tdata  <= item.data;
            gap_left <= pick_gap(tx_burst);
          end
          STIM_DRAIN: begin
            s_tvalid <= 1'b0;
            draining <= 1'b1;
          end
          default: begin
            s_tvalid <= 1'b0;
            hold_seq <= hold_seq + 1;
          end
        endcase
      end
    end
  end

  // Receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYC;
        m_tready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        stall_left <= pick_gap(rx_burst);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int r;
    int len;

    // directed: extremes, each sequence length, bad leads, malformed continuations
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h01);
    push_byte(8'hC3); push_byte(8'hA9);
    push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
    push_byte(8'hF0); push_byte(8'h9F); push_byte(8'h98); push_byte(8'h80);
    push_byte(8'hF8);
    push_byte(8'hFF);
    // continuation byte at a lead position, then a zero taken as continuation
    push_byte(8'h80); push_byte(8'h00);
    // bit 6 clear but bit 5 set: three-byte lead; ASCII and 0xFF as continuations
    push_byte(8'hA0); push_byte(8'h7F); push_byte(8'hFF);
    // largest four-byte value keeps all 21 bits
    push_byte(8'hF7); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
    push_byte(8'h00);
    push_marker(STIM_DRAIN);
    push_marker(STIM_HOLD);

    // random: mostly well-formed text, some noise and broken sequences
    while (n_bytes < N_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_sequence($urandom_range(1, 4));
      end else if (r < 78) begin
        push_byte(8'h00);
      end else if (r < 90) begin
        push_byte(ByteW'($urandom_range(0, 255)));
      end else begin
        // lead and continuations with the last byte arbitrary, which counts as a continuation anyway
        len = $urandom_range(2, 4);
        push_sequence(1 + (len - 1) * 0 + (len - 1));
        stim_q.pop_back();
        n_bytes--;
        push_byte(ByteW'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 299) == 0) push_marker(STIM_DRAIN);
      if ($urandom_range(0, 399) == 0) push_marker(STIM_HOLD);
    end
    push_marker(STIM_HOLD);

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (stim_q.size() != 0 || s_tvalid || draining || gap_left != 0 || cp_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    if (errors == 0 && cp_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #16_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
